// ===== rtl/vehicle_corner_list_engine_assert.svh =====
// Assertion macros shared by the corner list engine.
// Depends on nothing; include by bare file name.
`ifndef VEHICLE_CORNER_LIST_ENGINE_ASSERT_SVH
`define VEHICLE_CORNER_LIST_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VCLE_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VCLE_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/vcle_pkg.sv =====
// Package of the corner list engine: sizes, command codes, state and control types.
// Depends on nothing.
`timescale 1ns / 1ps
package vcle_pkg;
    localparam int LIST_CAPACITY = 9;
    localparam int IDX_W = $clog2(LIST_CAPACITY);
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int COL_W = 11;
    localparam int ROW_W = 10;
    localparam int SUM_W = 24;
    localparam int PC_W = 16;
    localparam int DIV_STEPS = SUM_W;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0, CMD_AGE = 2'd1, CMD_EXAMINE = 2'd2, CMD_PAIR = 2'd3
    } t_cmd;

    localparam logic CFG_NEAR = 1'b0;
    localparam logic CFG_GAP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_AGE, ST_PAIR, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture the request
        logic clear;     // clear lists and sums
        logic examine;   // append detected corners
        logic age_init;  // start aging walk
        logic age_step;  // age one entry of each list
        logic pair_init;
        logic pair_step; // test one left/right pair
        logic div_init;
        logic div_step;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic age_done;
        logic pair_done;
        logic div_done;
    } t_stat;
endpackage

// ===== rtl/vcle_ctrl.sv =====
// Controller state machine of the corner list engine.
// Depends on vcle_pkg.
`timescale 1ns / 1ps
module vcle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_command,
    input  logic             i_out_busy,
    input  vcle_pkg::t_stat  i_stat,
    output logic             o_stall,
    output vcle_pkg::t_ctrl  o_ctrl
);
    vcle_pkg::t_state r_state, n_state;
    logic [1:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcle_pkg::ST_IDLE;
            r_cmd <= 2'd0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.load) r_cmd <= i_command;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl = '0;
        o_stall = (r_state != vcle_pkg::ST_IDLE);
        unique case (r_state)
            vcle_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state = vcle_pkg::ST_EXEC;
                end
            end
            vcle_pkg::ST_EXEC: begin
                unique case (r_cmd)
                    vcle_pkg::CMD_CLEAR: begin
                        o_ctrl.clear = 1'b1;
                        n_state = vcle_pkg::ST_OUT;
                    end
                    vcle_pkg::CMD_AGE: begin
                        o_ctrl.age_init = 1'b1;
                        n_state = vcle_pkg::ST_AGE;
                    end
                    vcle_pkg::CMD_EXAMINE: begin
                        o_ctrl.examine = 1'b1;
                        n_state = vcle_pkg::ST_OUT;
                    end
                    default: begin
                        o_ctrl.pair_init = 1'b1;
                        n_state = vcle_pkg::ST_PAIR;
                    end
                endcase
            end
            vcle_pkg::ST_AGE: begin
                o_ctrl.age_step = 1'b1;
                if (i_stat.age_done) n_state = vcle_pkg::ST_OUT;
            end
            vcle_pkg::ST_PAIR: begin
                o_ctrl.pair_step = 1'b1;
                if (i_stat.pair_done) begin
                    o_ctrl.div_init = 1'b1;
                    n_state = vcle_pkg::ST_DIV;
                end
            end
            vcle_pkg::ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.div_done) n_state = vcle_pkg::ST_OUT;
            end
            vcle_pkg::ST_OUT: begin
                if (!i_out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = vcle_pkg::ST_IDLE;
                end
            end
            default: n_state = vcle_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/vcle_datapath.sv =====
// Datapath of the corner list engine: lists, mask logic, aging, pairing, division.
// Depends on vcle_pkg.
`timescale 1ns / 1ps
module vcle_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vcle_pkg::t_ctrl  i_ctrl,
    input  logic [1:0]       i_command,
    input  logic [9:0]       i_row,
    input  logic [10:0]      i_column,
    input  logic [32:0]      i_row_flags,
    input  logic [29:0]      i_above_flags,
    input  logic [14:0]      i_below_flags,
    input  logic [11:0]      i_min_width,
    input  logic [11:0]      i_max_width,
    input  logic [9:0]       i_near_row_limit,
    input  logic [9:0]       i_row_gap_limit,
    output vcle_pkg::t_stat  o_stat,
    output logic             o_res_found,
    output logic [10:0]      o_res_lmean,
    output logic [10:0]      o_res_rmean,
    output logic [15:0]      o_res_pairs,
    output logic [3:0]       o_res_lcnt,
    output logic [3:0]       o_res_rcnt
);
    localparam int N = vcle_pkg::LIST_CAPACITY;
    localparam int IW = vcle_pkg::IDX_W;
    localparam int CW = vcle_pkg::CNT_W;
    localparam int SW = vcle_pkg::SUM_W;
    localparam int PW = vcle_pkg::PC_W;

    logic [10:0] r_lcol [N];
    logic [9:0]  r_lrow [N];
    logic [10:0] r_rcol [N];
    logic [9:0]  r_rrow [N];
    logic [CW-1:0] r_lcnt, r_rcnt;
    logic [SW-1:0] r_lsum, r_rsum;
    logic [PW-1:0] r_pc;

    logic [9:0]  r_row;
    logic [10:0] r_col;
    logic [32:0] r_rf;
    logic [29:0] r_af;
    logic [14:0] r_bf;
    logic [11:0] r_wmin, r_wmax;
    logic        r_pair_cmd;

    // walk indexes: read pointer, write pointer per list
    logic [CW-1:0] r_li, r_ri, r_lk, r_rk;
    // divider
    logic [SW-1:0] r_ql, r_qr;
    logic [PW:0]   r_reml, r_remr;
    logic [4:0]    r_dstep;

    // pixel class helpers
    function automatic logic cur_h(input logic [32:0] f, input int o);
        return f[o + 5];
    endfunction
    function automatic logic cur_v(input logic [32:0] f, input int o);
        return f[o + 16];
    endfunction
    function automatic logic cur_s(input logic [32:0] f, input int o);
        return f[o + 27];
    endfunction

    logic big, ok_e, ok_s, lclear, rclear, lh, rh, sl, sr;
    logic [2:0] n_ladd, n_radd;
    always_comb begin
        big = (r_row <= i_near_row_limit);
        ok_e = cur_h(r_rf, 0) | cur_v(r_rf, 0);
        for (int k = 1; k <= 7; k++)
            if ((big || k <= 5) && !(r_af[k+9] && !r_af[k-1])) ok_e = 1'b0;
        for (int k = 1; k <= 5; k++)
            if ((big || k <= 3) && (r_bf[k-1] || r_bf[k+4])) ok_e = 1'b0;
        lclear = 1'b1;
        rclear = 1'b1;
        for (int k = 1; k <= 3; k++) begin
            if (cur_h(r_rf, -k) || cur_v(r_rf, -k)) lclear = 1'b0;
            if (cur_h(r_rf, k) || cur_v(r_rf, k)) rclear = 1'b0;
        end
        lh = 1'b1;
        rh = 1'b1;
        for (int k = 1; k <= 5; k++) if (big || k <= 3) begin
            if (!(cur_h(r_rf, k) && !cur_v(r_rf, k))) lh = 1'b0;
            if (!(cur_h(r_rf, -k) && !cur_v(r_rf, -k))) rh = 1'b0;
        end
        ok_s = cur_s(r_rf, 0);
        for (int k = 1; k <= 10; k++)
            if ((big || k <= 5) && !r_af[k+19]) ok_s = 1'b0;
        for (int k = 1; k <= 5; k++)
            if ((big || k <= 3) && r_bf[k+9]) ok_s = 1'b0;
        sl = ok_s;
        sr = ok_s;
        for (int k = 1; k <= 5; k++) begin
            if ((big || k <= 3) && cur_s(r_rf, -k)) sl = 1'b0;
            if (!cur_s(r_rf, k)) sl = 1'b0;
            if ((big || k <= 3) && cur_s(r_rf, k)) sr = 1'b0;
            if (!cur_s(r_rf, -k)) sr = 1'b0;
        end
        n_ladd = 3'({2'b0, ok_e & lclear & lh}) + 3'({2'b0, ok_e & lclear})
               + 3'({2'b0, sl});
        n_radd = 3'({2'b0, ok_e & rclear & rh}) + 3'({2'b0, ok_e & rclear})
               + 3'({2'b0, sr});
    end

    logic age_done, pair_done, div_done;

    // aging tests on the entry at each read pointer
    logic l_in, r_in, l_keep, r_keep;
    logic [9:0] lr, rr, ld, rd;
    logic [IW-1:0] lidx, ridx, lkx, rkx;
    always_comb begin
        l_in = (r_li < r_lcnt);
        r_in = (r_ri < r_rcnt);
        lidx = l_in ? r_li[IW-1:0] : '0;
        ridx = r_in ? r_ri[IW-1:0] : '0;
        lkx = r_lk[IW-1:0];
        rkx = r_rk[IW-1:0];
        lr = r_lrow[lidx];
        rr = r_rrow[ridx];
        ld = (r_row >= lr) ? r_row - lr : lr - r_row;
        rd = (r_row >= rr) ? r_row - rr : rr - r_row;
        l_keep = (lr == 10'd0) || (ld < i_row_gap_limit);
        r_keep = (rr == 10'd0) || (rd < i_row_gap_limit);
        age_done = !l_in && !r_in;
    end

    // pair test: r_li indexes left, r_ri indexes right
    logic p_in, p_match, p_last;
    logic [10:0] pl, pr;
    logic [11:0] span;
    logic [SW:0] lsum_a, rsum_a;
    always_comb begin
        p_in = (r_li < r_lcnt) && (r_ri < r_rcnt);
        pl = r_lcol[lidx];
        pr = r_rcol[ridx];
        span = {1'b0, pr} - {1'b0, pl} + 12'd1;
        p_match = p_in && (pr > pl) && (span >= r_wmin) && (span <= r_wmax);
        lsum_a = {1'b0, r_lsum} + (SW+1)'(pl);
        rsum_a = {1'b0, r_rsum} + (SW+1)'(pr);
        p_last = (r_ri + CW'(1) >= r_rcnt);
        pair_done = !p_in;
    end

    // restoring division step for both sums by r_pc
    logic [PW:0] dl_t, dr_t;
    always_comb begin
        dl_t = {r_reml[PW-1:0], r_ql[SW-1]};
        dr_t = {r_remr[PW-1:0], r_qr[SW-1]};
        div_done = (r_dstep == 5'(vcle_pkg::DIV_STEPS));
    end

    assign o_stat = {age_done, pair_done, div_done};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_row <= i_row;
            r_col <= i_column;
            r_rf <= i_row_flags;
            r_af <= i_above_flags;
            r_bf <= i_below_flags;
            r_wmin <= i_min_width;
            r_wmax <= i_max_width;
            r_pair_cmd <= (i_command == vcle_pkg::CMD_PAIR);
        end
        if (i_ctrl.div_init) begin
            r_ql <= r_lsum;
            r_qr <= r_rsum;
            r_reml <= '0;
            r_remr <= '0;
            r_dstep <= '0;
        end else if (i_ctrl.div_step && !div_done) begin
            r_dstep <= r_dstep + 5'd1;
            if (dl_t >= {1'b0, r_pc}) begin
                r_reml <= dl_t - {1'b0, r_pc};
                r_ql <= {r_ql[SW-2:0], 1'b1};
            end else begin
                r_reml <= dl_t;
                r_ql <= {r_ql[SW-2:0], 1'b0};
            end
            if (dr_t >= {1'b0, r_pc}) begin
                r_remr <= dr_t - {1'b0, r_pc};
                r_qr <= {r_qr[SW-2:0], 1'b1};
            end else begin
                r_remr <= dr_t;
                r_qr <= {r_qr[SW-2:0], 1'b0};
            end
        end
        if (i_ctrl.out_load) begin
            o_res_found <= r_pair_cmd && (r_pc != '0);
            o_res_lmean <= (r_pair_cmd && r_pc != '0) ? r_ql[10:0] : 11'd0;
            o_res_rmean <= (r_pair_cmd && r_pc != '0) ? r_qr[10:0] : 11'd0;
            o_res_pairs <= r_pc;
            o_res_lcnt <= 4'(r_lcnt);
            o_res_rcnt <= 4'(r_rcnt);
        end
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_lcnt <= '0;
            r_rcnt <= '0;
            r_lsum <= '0;
            r_rsum <= '0;
            r_pc <= '0;
            for (int i = 0; i < N; i++) begin
                r_lcol[i] <= '0;
                r_lrow[i] <= '0;
                r_rcol[i] <= '0;
                r_rrow[i] <= '0;
            end
            r_li <= '0;
            r_ri <= '0;
            r_lk <= '0;
            r_rk <= '0;
        end else begin
            if (i_ctrl.examine) begin
                for (int a = 0; a < 3; a++) begin
                    if (3'(a) < n_ladd && r_lcnt + CW'(a) < CW'(N)) begin
                        r_lcol[IW'(r_lcnt + CW'(a))] <= r_col;
                        r_lrow[IW'(r_lcnt + CW'(a))] <= r_row;
                    end
                    if (3'(a) < n_radd && r_rcnt + CW'(a) < CW'(N)) begin
                        r_rcol[IW'(r_rcnt + CW'(a))] <= r_col;
                        r_rrow[IW'(r_rcnt + CW'(a))] <= r_row;
                    end
                end
                r_lcnt <= ((CW+1)'(r_lcnt) + (CW+1)'(n_ladd) > (CW+1)'(N)) ? CW'(N)
                        : r_lcnt + CW'(n_ladd);
                r_rcnt <= ((CW+1)'(r_rcnt) + (CW+1)'(n_radd) > (CW+1)'(N)) ? CW'(N)
                        : r_rcnt + CW'(n_radd);
            end
            if (i_ctrl.age_init || i_ctrl.pair_init) begin
                r_li <= '0;
                r_ri <= '0;
                r_lk <= '0;
                r_rk <= '0;
            end
            if (i_ctrl.age_init) begin
                r_lsum <= '0;
                r_rsum <= '0;
                r_pc <= '0;
            end
            if (i_ctrl.age_step) begin
                if (l_in) begin
                    r_li <= r_li + CW'(1);
                    if (l_keep) begin
                        r_lcol[lkx] <= r_lcol[lidx];
                        r_lrow[lkx] <= lr;
                        r_lk <= r_lk + CW'(1);
                    end
                end else begin
                    r_lcnt <= r_lk;
                    for (int i = 0; i < N; i++)
                        if (CW'(i) >= r_lk) begin
                            r_lcol[i] <= '0;
                            r_lrow[i] <= '0;
                        end
                end
                if (r_in) begin
                    r_ri <= r_ri + CW'(1);
                    if (r_keep) begin
                        r_rcol[rkx] <= r_rcol[ridx];
                        r_rrow[rkx] <= rr;
                        r_rk <= r_rk + CW'(1);
                    end
                end else begin
                    r_rcnt <= r_rk;
                    for (int i = 0; i < N; i++)
                        if (CW'(i) >= r_rk) begin
                            r_rcol[i] <= '0;
                            r_rrow[i] <= '0;
                        end
                end
            end
            if (i_ctrl.pair_step && p_in) begin
                if (p_last) begin
                    r_ri <= '0;
                    r_li <= r_li + CW'(1);
                end else begin
                    r_ri <= r_ri + CW'(1);
                end
                if (p_match) begin
                    r_lsum <= lsum_a[SW] ? '1 : lsum_a[SW-1:0];
                    r_rsum <= rsum_a[SW] ? '1 : rsum_a[SW-1:0];
                    if (r_pc != '1) r_pc <= r_pc + PW'(1);
                end
            end
        end
    end
endmodule

// ===== rtl/vehicle_corner_list_engine.sv =====
// Corner list engine top level: config registers, output stage, controller, datapath.
// Depends on vcle_pkg, vcle_ctrl, vcle_datapath and the assertion header.
`timescale 1ns / 1ps
// Each request carries one command and yields one result. Clear and examine pass through
// the execute and output states and put their result in the output register; age walks
// both lists one entry per cycle and loads its result once the longer list is done; pair
// walks every left/right combination one per cycle and then runs two 24-step restoring
// dividers side by side for the means. The next request is accepted only once a result
// is loaded, so the block takes one request at a time. The result sits in an output
// register, and a new request is taken while it waits to be collected.
module vehicle_corner_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_row,
    input  logic [10:0] i_column,
    input  logic [32:0] i_row_flags,
    input  logic [29:0] i_above_flags,
    input  logic [14:0] i_below_flags,
    input  logic [11:0] i_min_width,
    input  logic [11:0] i_max_width,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_pair_found,
    output logic [10:0] o_left_mean,
    output logic [10:0] o_right_mean,
    output logic [15:0] o_pair_total,
    output logic [3:0]  o_left_total,
    output logic [3:0]  o_right_total
);
`include "vehicle_corner_list_engine_assert.svh"

    logic [9:0] r_near, r_gap;
    logic r_out_valid;
    vcle_pkg::t_ctrl ctrl;
    vcle_pkg::t_stat stat;

    // Configuration writes land directly in the registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= 10'd0;
            r_gap <= 10'd8;
        end else if (i_cfg_we) begin
            if (i_cfg_index == vcle_pkg::CFG_NEAR) r_near <= i_cfg_data;
            else r_gap <= i_cfg_data;
        end
    end

    // The output register holds a result until the far side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (ctrl.out_load) r_out_valid <= 1'b1;
        else if (!i_stall) r_out_valid <= 1'b0;
    end
    assign o_valid = r_out_valid;

    vcle_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_command(i_command),
        .i_out_busy(r_out_valid && i_stall), .i_stat(stat),
        .o_stall(o_stall), .o_ctrl(ctrl)
    );

    vcle_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_command(i_command),
        .i_row(i_row), .i_column(i_column), .i_row_flags(i_row_flags),
        .i_above_flags(i_above_flags), .i_below_flags(i_below_flags),
        .i_min_width(i_min_width), .i_max_width(i_max_width),
        .i_near_row_limit(r_near), .i_row_gap_limit(r_gap), .o_stat(stat),
        .o_res_found(o_pair_found), .o_res_lmean(o_left_mean),
        .o_res_rmean(o_right_mean), .o_res_pairs(o_pair_total),
        .o_res_lcnt(o_left_total), .o_res_rcnt(o_right_total)
    );

    // A result is only loaded when the output register is free or being emptied.
    `VCLE_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, ctrl.out_load, !(r_out_valid && i_stall))
    // Stored counts never pass the list capacity.
    `VCLE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, o_valid,
        (o_left_total <= 4'(vcle_pkg::LIST_CAPACITY)) &&
        (o_right_total <= 4'(vcle_pkg::LIST_CAPACITY)))
    // An accepted request keeps the input side stalled on the next cycle.
    `VCLE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

// ===== dv/vehicle_corner_list_engine_tb.sv =====
// Self-checking testbench for the vehicle corner list engine: random and directed requests,
// checked one result at a time against an in-bench model of the two corner lists.
// Depends on vcle_pkg and vehicle_corner_list_engine.
`timescale 1ns / 1ps
module vehicle_corner_list_engine_tb;
    localparam int CAP       = vcle_pkg::LIST_CAPACITY;
    localparam int LIMIT     = 3000000;
    localparam int HOLD_LEN  = 400;
    localparam int SUM_LIM   = 24'hFFFFFF;
    localparam int CNT_LIM   = 16'hFFFF;
    // Pixel classes: bit 0 horizontal edge, bit 1 vertical edge.
    localparam logic [1:0] CLS_NONE = 2'b00;
    localparam logic [1:0] CLS_H    = 2'b01;
    localparam logic [1:0] CLS_V    = 2'b10;
    // Shapes of examine requests built to pass the corner masks.
    localparam int SHAPE_EDGE_L = 0;
    localparam int SHAPE_EDGE_R = 1;
    localparam int SHAPE_SHAD_L = 2;
    localparam int SHAPE_SHAD_R = 3;

    typedef struct {
        vcle_pkg::t_cmd cmd;
        logic [9:0]  row;
        logic [10:0] column;
        logic [32:0] row_flags;
        logic [29:0] above_flags;
        logic [14:0] below_flags;
        logic [11:0] min_width;
        logic [11:0] max_width;
    } t_request;

    typedef struct {
        logic        found;
        logic [10:0] left_mean;
        logic [10:0] right_mean;
        logic [15:0] pair_total;
        logic [3:0]  left_total;
        logic [3:0]  right_total;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [9:0]  i_row;
    logic [10:0] i_column;
    logic [32:0] i_row_flags;
    logic [29:0] i_above_flags;
    logic [14:0] i_below_flags;
    logic [11:0] i_min_width;
    logic [11:0] i_max_width;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic        o_pair_found;
    logic [10:0] o_left_mean;
    logic [10:0] o_right_mean;
    logic [15:0] o_pair_total;
    logic [3:0]  o_left_total;
    logic [3:0]  o_right_total;

    vehicle_corner_list_engine u_dut (.*);

    // Pending requests for the driver and results still owed by the block.
    t_request pending_reqs[$];
    t_result  owed_results[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_request;
    int   hold_left;
    bit   took_req;
    int   error_count;
    int   cycle_count;

    // Shadow copy of the block's registers and corner lists.
    logic [9:0]  near_limit;
    logic [9:0]  gap_limit;
    int unsigned left_col[CAP];
    int unsigned left_row[CAP];
    int unsigned right_col[CAP];
    int unsigned right_row[CAP];
    int unsigned left_n;
    int unsigned right_n;
    int unsigned left_acc;
    int unsigned right_acc;
    int unsigned pairs_acc;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [1:0] cls_here(logic [32:0] rf, int off);
        int p;
        p = off + 5;
        return {rf[11 + p], rf[p]};
    endfunction

    function automatic logic sh_here(logic [32:0] rf, int off);
        return rf[22 + off + 5];
    endfunction

    function automatic bit side_cls(logic [32:0] rf, int sign, int n, logic [1:0] cls);
        for (int i = 1; i <= n; i++) begin
            if (cls_here(rf, sign * i) != cls) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit side_sh(logic [32:0] rf, int sign, int n, logic s);
        for (int i = 1; i <= n; i++) begin
            if (sh_here(rf, sign * i) != s) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Appends are dropped once a list holds its full capacity.
    function automatic void add_corner(bit on_right, int unsigned col, int unsigned row);
        if (!on_right && left_n < CAP) begin
            left_col[left_n] = col;
            left_row[left_n] = row;
            left_n++;
        end else if (on_right && right_n < CAP) begin
            right_col[right_n] = col;
            right_row[right_n] = row;
            right_n++;
        end
    endfunction

    function automatic void scan_pixel(t_request r);
        bit big, ok, lclear, rclear;
        int up_e, dn, up_s, w;
        big  = r.row <= near_limit;
        up_e = big ? 7 : 5;
        dn   = big ? 5 : 3;
        up_s = big ? 10 : 5;
        w    = big ? 5 : 3;
        if (cls_here(r.row_flags, 0) != CLS_NONE) begin
            ok = 1'b1;
            for (int k = 1; k <= up_e; k++) begin
                if ({r.above_flags[9 + k], r.above_flags[k - 1]} != CLS_V) ok = 1'b0;
            end
            for (int k = 1; k <= dn; k++) begin
                if ({r.below_flags[4 + k], r.below_flags[k - 1]} != CLS_NONE) ok = 1'b0;
            end
            if (ok) begin
                lclear = side_cls(r.row_flags, -1, 3, CLS_NONE);
                rclear = side_cls(r.row_flags, 1, 3, CLS_NONE);
                if (lclear && side_cls(r.row_flags, 1, w, CLS_H)) add_corner(0, r.column, r.row);
                if (lclear) add_corner(0, r.column, r.row);
                if (rclear && side_cls(r.row_flags, -1, w, CLS_H)) add_corner(1, r.column, r.row);
                if (rclear) add_corner(1, r.column, r.row);
            end
        end
        if (sh_here(r.row_flags, 0)) begin
            ok = 1'b1;
            for (int k = 1; k <= up_s; k++) begin
                if (!r.above_flags[19 + k]) ok = 1'b0;
            end
            for (int k = 1; k <= dn; k++) begin
                if (r.below_flags[9 + k]) ok = 1'b0;
            end
            if (ok) begin
                if (side_sh(r.row_flags, -1, w, 1'b0) && side_sh(r.row_flags, 1, 5, 1'b1))
                    add_corner(0, r.column, r.row);
                if (side_sh(r.row_flags, 1, w, 1'b0) && side_sh(r.row_flags, -1, 5, 1'b1))
                    add_corner(1, r.column, r.row);
            end
        end
    endfunction

    // Entries with a nonzero row whose distance from the request row is at or beyond the
    // gap limit are dropped, the rest slide down in their original order.
    function automatic void age_side(bit on_right, int unsigned row);
        int unsigned kept, r, c, d, n;
        kept = 0;
        n = on_right ? right_n : left_n;
        for (int i = 0; i < n; i++) begin
            r = on_right ? right_row[i] : left_row[i];
            c = on_right ? right_col[i] : left_col[i];
            d = row >= r ? row - r : r - row;
            if (r != 0 && d >= gap_limit) continue;
            if (on_right) begin
                right_col[kept] = c;
                right_row[kept] = r;
            end else begin
                left_col[kept] = c;
                left_row[kept] = r;
            end
            kept++;
        end
        for (int i = kept; i < CAP; i++) begin
            if (on_right) begin
                right_col[i] = 0;
                right_row[i] = 0;
            end else begin
                left_col[i] = 0;
                left_row[i] = 0;
            end
        end
        if (on_right) right_n = kept;
        else left_n = kept;
    endfunction

    function automatic void wipe_lists();
        for (int i = 0; i < CAP; i++) begin
            left_col[i] = 0;
            left_row[i] = 0;
            right_col[i] = 0;
            right_row[i] = 0;
        end
        left_n = 0;
        right_n = 0;
        left_acc = 0;
        right_acc = 0;
        pairs_acc = 0;
    endfunction

    function automatic t_result corner_step(t_request r);
        t_result res;
        int unsigned l, rc, span;
        res.found = 1'b0;
        res.left_mean = '0;
        res.right_mean = '0;
        case (r.cmd)
            vcle_pkg::CMD_CLEAR: wipe_lists();
            vcle_pkg::CMD_AGE: begin
                age_side(0, r.row);
                age_side(1, r.row);
                left_acc = 0;
                right_acc = 0;
                pairs_acc = 0;
            end
            vcle_pkg::CMD_EXAMINE: scan_pixel(r);
            vcle_pkg::CMD_PAIR: begin
                for (int i = 0; i < left_n; i++) begin
                    for (int j = 0; j < right_n; j++) begin
                        l = left_col[i];
                        rc = right_col[j];
                        if (rc > l) begin
                            span = rc - l + 1;
                            if (span >= r.min_width && span <= r.max_width) begin
                                left_acc = (left_acc + l > SUM_LIM) ? SUM_LIM : left_acc + l;
                                right_acc = (right_acc + rc > SUM_LIM) ? SUM_LIM : right_acc + rc;
                                pairs_acc = (pairs_acc + 1 > CNT_LIM) ? CNT_LIM : pairs_acc + 1;
                            end
                        end
                    end
                end
                if (pairs_acc != 0) begin
                    res.found = 1'b1;
                    res.left_mean = 11'(left_acc / pairs_acc);
                    res.right_mean = 11'(right_acc / pairs_acc);
                end
            end
        endcase
        res.pair_total = 16'(pairs_acc);
        res.left_total = 4'(left_n);
        res.right_total = 4'(right_n);
        return res;
    endfunction

    // Driver: a new request goes out only after the previous one was taken.
    always @(negedge i_clk) begin
        t_request r;
        if (i_rst_n && (!i_valid || took_req)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                r = pending_reqs.pop_front();
                i_command <= r.cmd;
                i_row <= r.row;
                i_column <= r.column;
                i_row_flags <= r.row_flags;
                i_above_flags <= r.above_flags;
                i_below_flags <= r.below_flags;
                i_min_width <= r.min_width;
                i_max_width <= r.max_width;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, with an optional long hold-off that lets the block
    // fill up and stall the request side.
    always @(negedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge i_clk) begin
        t_request r;
        t_result exp_res;
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("%0t: timeout", $time);
            $display("vehicle_corner_list_engine_tb: errors");
            $finish;
        end else if (i_rst_n) begin
            took_req <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                r.cmd = vcle_pkg::t_cmd'(i_command);
                r.row = i_row;
                r.column = i_column;
                r.row_flags = i_row_flags;
                r.above_flags = i_above_flags;
                r.below_flags = i_below_flags;
                r.min_width = i_min_width;
                r.max_width = i_max_width;
                owed_results.push_back(corner_step(r));
            end
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, found %0d lmean %0d rmean %0d total %0d",
                             $time, o_pair_found, o_left_mean, o_right_mean, o_pair_total);
                    error_count++;
                end else begin
                    exp_res = owed_results.pop_front();
                    if (o_pair_found !== exp_res.found ||
                        o_left_mean !== exp_res.left_mean ||
                        o_right_mean !== exp_res.right_mean ||
                        o_pair_total !== exp_res.pair_total ||
                        o_left_total !== exp_res.left_total ||
                        o_right_total !== exp_res.right_total) begin
                        $display("%0t: expected found %0d lmean %0d rmean %0d pairs %0d L %0d R %0d",
                                 $time, exp_res.found, exp_res.left_mean, exp_res.right_mean,
                                 exp_res.pair_total, exp_res.left_total, exp_res.right_total);
                        $display("%0t: actual   found %0d lmean %0d rmean %0d pairs %0d L %0d R %0d",
                                 $time, o_pair_found, o_left_mean, o_right_mean,
                                 o_pair_total, o_left_total, o_right_total);
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic t_request plain_req(vcle_pkg::t_cmd cmd, int row);
        t_request r;
        r.cmd = cmd;
        r.row = 10'(row);
        r.column = 11'($urandom_range(2047));
        r.row_flags = 33'({$urandom(), $urandom()});
        r.above_flags = 30'($urandom());
        r.below_flags = 15'($urandom());
        r.min_width = 12'($urandom_range(2048));
        r.max_width = 12'($urandom_range(2048));
        return r;
    endfunction

    // Examine request whose flags match one corner mask; other bits stay random.
    function automatic t_request corner_req(int shape, int row, int col);
        t_request r;
        r = plain_req(vcle_pkg::CMD_EXAMINE, row);
        r.column = 11'(col);
        case (shape)
            SHAPE_EDGE_L, SHAPE_EDGE_R: begin
                r.row_flags[5] = 1'b1;
                for (int k = 1; k <= 7; k++) begin
                    r.above_flags[k - 1] = 1'b0;
                    r.above_flags[9 + k] = 1'b1;
                end
                r.below_flags[9:0] = '0;
                for (int i = 1; i <= 5; i++) begin
                    if (shape == SHAPE_EDGE_L) begin
                        if (i <= 3) {r.row_flags[16 - i], r.row_flags[5 - i]} = CLS_NONE;
                        {r.row_flags[16 + i], r.row_flags[5 + i]} = CLS_H;
                    end else begin
                        if (i <= 3) {r.row_flags[16 + i], r.row_flags[5 + i]} = CLS_NONE;
                        {r.row_flags[16 - i], r.row_flags[5 - i]} = CLS_H;
                    end
                end
            end
            default: begin
                r.row_flags[27] = 1'b1;
                r.above_flags[29:20] = '1;
                r.below_flags[14:10] = '0;
                for (int i = 1; i <= 5; i++) begin
                    r.row_flags[27 - i] = (shape == SHAPE_SHAD_R);
                    r.row_flags[27 + i] = (shape == SHAPE_SHAD_L);
                end
            end
        endcase
        // Break a mask now and then.
        if ($urandom_range(3) == 0) r.row_flags[$urandom_range(32)] ^= 1'b1;
        if ($urandom_range(5) == 0) r.above_flags[$urandom_range(29)] ^= 1'b1;
        if ($urandom_range(5) == 0) r.below_flags[$urandom_range(14)] ^= 1'b1;
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || owed_results.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == vcle_pkg::CFG_NEAR) near_limit = value;
        else gap_limit = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, int row_base);
        int row, pick, c;
        t_request r;
        row = row_base;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if ($urandom_range(15) == 0) row = $urandom_range(1023);
            else if ($urandom_range(3) == 0) row = (row + 1) % 1024;
            c = $urandom_range(2047);
            if (pick < 55) begin
                r = corner_req($urandom_range(3), ($urandom_range(19) == 0) ? 0 : row, c);
            end else if (pick < 65) begin
                r = plain_req(vcle_pkg::CMD_EXAMINE, row);
            end else if (pick < 82) begin
                r = plain_req(vcle_pkg::CMD_PAIR, row);
                if ($urandom_range(3) != 0) begin
                    r.min_width = 12'($urandom_range(300));
                    r.max_width = 12'($urandom_range(300, 2048));
                end
            end else if (pick < 97) begin
                r = plain_req(vcle_pkg::CMD_AGE, row);
            end else begin
                r = plain_req(vcle_pkg::CMD_CLEAR, row);
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        t_request r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_command = vcle_pkg::CMD_CLEAR;
        i_row = '0;
        i_column = '0;
        i_row_flags = '0;
        i_above_flags = '0;
        i_below_flags = '0;
        i_min_width = '0;
        i_max_width = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = vcle_pkg::CFG_NEAR;
        i_cfg_data = '0;
        took_req = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        near_limit = 10'd0;
        gap_limit = 10'd8;
        wipe_lists();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every mask in big and small form, row-zero entries, field extremes,
        // inverted width bounds and a gap limit of zero.
        write_reg(vcle_pkg::CFG_NEAR, 10'd100);
        write_reg(vcle_pkg::CFG_GAP, 10'd8);
        for (int s = 0; s < 4; s++) begin
            pending_reqs.push_back(corner_req(s, 50, 300 + s * 200));
            pending_reqs.push_back(corner_req(s, 700, 400 + s * 300));
        end
        pending_reqs.push_back(corner_req(SHAPE_SHAD_L, 0, 2047));
        pending_reqs.push_back(corner_req(SHAPE_SHAD_R, 1023, 0));
        r = plain_req(vcle_pkg::CMD_PAIR, 5);
        r.min_width = 12'd0;
        r.max_width = 12'd2048;
        pending_reqs.push_back(r);
        r.min_width = 12'd2048;
        r.max_width = 12'd0;
        pending_reqs.push_back(r);
        r = plain_req(vcle_pkg::CMD_EXAMINE, 1023);
        r.column = 11'd2047;
        r.row_flags = '1;
        r.above_flags = '1;
        r.below_flags = '1;
        pending_reqs.push_back(r);
        r.row = 10'd0;
        r.column = 11'd0;
        r.row_flags = '0;
        r.above_flags = '0;
        r.below_flags = '0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_AGE, 1023));
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_PAIR, 1023));
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_CLEAR, 0));
        drain();
        write_reg(vcle_pkg::CFG_GAP, 10'd0);
        pending_reqs.push_back(corner_req(SHAPE_SHAD_L, 3, 10));
        pending_reqs.push_back(corner_req(SHAPE_EDGE_R, 0, 20));
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_AGE, 3));
        drain();

        // Full lists and saturating sums: far-apart pairs walked many times.
        write_reg(vcle_pkg::CFG_NEAR, 10'd1023);
        write_reg(vcle_pkg::CFG_GAP, 10'd1023);
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_CLEAR, 0));
        for (int i = 0; i < 20; i++) begin
            pending_reqs.push_back(corner_req(SHAPE_SHAD_L, 10, $urandom_range(1500, 1700)));
            pending_reqs.push_back(corner_req(SHAPE_SHAD_R, 10, $urandom_range(1900, 2047)));
        end
        for (int i = 0; i < 830; i++) begin
            r = plain_req(vcle_pkg::CMD_PAIR, 10);
            r.min_width = 12'd0;
            r.max_width = 12'd2048;
            pending_reqs.push_back(r);
        end
        pending_reqs.push_back(plain_req(vcle_pkg::CMD_AGE, 10));
        drain();

        // Random phases: sender idles lightly, then the receiver, then nobody, with one long result-side hold-off.
        write_reg(vcle_pkg::CFG_NEAR, 10'd512);
        write_reg(vcle_pkg::CFG_GAP, 10'd1);
        send_idle_pct = 22;
        recv_idle_pct = 53;
        random_phase(186, 100);
        drain();
        write_reg(vcle_pkg::CFG_NEAR, 10'd0);
        write_reg(vcle_pkg::CFG_GAP, 10'd12);
        send_idle_pct = 53;
        recv_idle_pct = 22;
        random_phase(186, 600);
        drain();
        write_reg(vcle_pkg::CFG_NEAR, 10'($urandom_range(1023)));
        write_reg(vcle_pkg::CFG_GAP, 10'($urandom_range(1, 1023)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        random_phase(186, 900);
        drain();

        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("vehicle_corner_list_engine_tb: clean");
        end else begin
            $display("vehicle_corner_list_engine_tb: errors");
        end
        $finish;
    end
endmodule

// ===== vehicle_corner_list_engine.f =====
+incdir+rtl
rtl/vcle_pkg.sv
rtl/vcle_ctrl.sv
rtl/vcle_datapath.sv
rtl/vehicle_corner_list_engine.sv
dv/vehicle_corner_list_engine_tb.sv
